// ===== rtl/vsh_pkg.sv =====
// Package for the visited signature hash set.
// Sizes, signature and result types, controller state codes.
// No dependencies.
package vsh_pkg;

    localparam int NUM_BUCKETS = 4096;
    localparam int BUCKET_WAYS = 4;

    localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
    localparam int WAY_BITS    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int FILL_BITS   = $clog2(BUCKET_WAYS + 1);
    localparam int SLOT_BITS   = BUCKET_BITS + WAY_BITS;
    localparam int SLOT_COUNT  = 1 << SLOT_BITS;

    localparam int PATH_W = 64;
    localparam int DEV_W  = 32;
    localparam int TYPE_W = 8;
    localparam int SIG_W  = PATH_W + DEV_W + TYPE_W;

    localparam logic KIND_TEST  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [PATH_W-1:0] path;
        logic [DEV_W-1:0]  dev;
        logic [TYPE_W-1:0] typ;
    } sig_t;

    typedef struct packed {
        logic seen;
        logic full;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FILL  = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

endpackage

// ===== rtl/vsh_ram.sv =====
// Generic single-write, single-read synchronous RAM.
// Registered read. No dependencies.
module vsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/vsh_out_stage.sv =====
// Output register for the result channel.
// Decouples the controller from a stalling receiver. Uses vsh_pkg.
module vsh_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  vsh_pkg::result_t load_res,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             already_seen,
    output logic             bucket_full
);

    logic             valid_reg;
    logic             valid_next;
    vsh_pkg::result_t res_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load_valid && load_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid    = valid_reg;
    assign already_seen = res_reg.seen;
    assign bucket_full  = res_reg.full;

endmodule

// ===== rtl/visited_signature_hash_set.sv =====
// Top level of the visited signature hash set: test-and-insert controller.
// Uses vsh_pkg, vsh_ram (fill counts and slot store) and vsh_out_stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries kind, path_id, device_num,
//   server_type. Output channel (out_valid/out_ready) carries one result
//   per input item: already_seen and bucket_full.
//   A test item reads the fill count of bucket path_id[11:0], then reads
//   and compares the filled slots one per cycle from the slot RAM port.
//   The item then passes through FILL, through CMP once per compared slot
//   (up to four, none for an empty bucket) and FIN to the output register.
//   The next item can be accepted in the cycle after the result is handed
//   to the output register.
//   A clear item sweeps the fill-count RAM one bucket per cycle, then its
//   result is issued.
//   After reset the same sweep runs with in_ready low.
//   A stalled receiver holds the result in the output register; one more
//   result can finish behind it, then in_ready stays low until a transfer.
module visited_signature_hash_set (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] path_id,
    input  logic [31:0] device_num,
    input  logic [7:0]  server_type,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        already_seen,
    output logic        bucket_full
);

    localparam int BB = vsh_pkg::BUCKET_BITS;
    localparam int WB = vsh_pkg::WAY_BITS;
    localparam int FB = vsh_pkg::FILL_BITS;

    vsh_pkg::state_t  state_reg, state_next;
    vsh_pkg::sig_t    key_reg, key_next;
    logic [BB-1:0]    bucket_reg, bucket_next;
    logic [FB-1:0]    fill_reg, fill_next;
    logic [FB-1:0]    way_reg, way_next;
    logic [BB-1:0]    clr_addr_reg, clr_addr_next;
    logic             clr_item_reg, clr_item_next;
    vsh_pkg::result_t res_reg, res_next;

    logic             in_fire;
    logic             load_ready;
    logic             load_valid;

    logic             fill_we;
    logic [BB-1:0]    fill_waddr;
    logic [FB-1:0]    fill_wdata;
    logic [BB-1:0]    fill_raddr;
    logic [FB-1:0]    fill_rdata;
    logic [FB-1:0]    fill_clamped;

    logic             slot_we;
    logic [vsh_pkg::SLOT_BITS-1:0] slot_waddr;
    logic [vsh_pkg::SLOT_BITS-1:0] slot_raddr;
    vsh_pkg::sig_t    slot_rdata;
    logic [FB-1:0]    way_plus;
    logic             slot_match;

    assign in_ready   = (state_reg == vsh_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign load_valid = (state_reg == vsh_pkg::ST_FIN);

    assign fill_clamped = (fill_rdata > FB'(vsh_pkg::BUCKET_WAYS))
                        ? FB'(vsh_pkg::BUCKET_WAYS) : fill_rdata;
    assign way_plus     = way_reg + FB'(1);
    assign slot_match   = (slot_rdata == key_reg);
    assign slot_waddr   = (state_reg == vsh_pkg::ST_FILL) ? {bucket_reg, {WB{1'b0}}}
                        : {bucket_reg, fill_reg[WB-1:0]};

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        bucket_next   = bucket_reg;
        fill_next     = fill_reg;
        way_next      = way_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        res_next      = res_reg;
        fill_we       = 1'b0;
        fill_waddr    = bucket_reg;
        fill_wdata    = fill_reg + FB'(1);
        fill_raddr    = bucket_reg;
        slot_we       = 1'b0;
        slot_raddr    = {bucket_reg, way_plus[WB-1:0]};

        case (state_reg)
            vsh_pkg::ST_CLEAR:
            begin
                fill_we       = 1'b1;
                fill_waddr    = clr_addr_reg;
                fill_wdata    = '0;
                clr_addr_next = clr_addr_reg + BB'(1);
                if (clr_addr_reg == BB'(vsh_pkg::NUM_BUCKETS - 1))
                begin
                    res_next   = '{seen: 1'b0, full: 1'b0};
                    state_next = clr_item_reg ? vsh_pkg::ST_FIN : vsh_pkg::ST_IDLE;
                end
            end
            vsh_pkg::ST_IDLE:
            begin
                fill_raddr = path_id[BB-1:0];
                if (in_fire)
                begin
                    key_next    = '{path: path_id, dev: device_num, typ: server_type};
                    bucket_next = path_id[BB-1:0];
                    if (kind == vsh_pkg::KIND_CLEAR)
                    begin
                        clr_addr_next = '0;
                        clr_item_next = 1'b1;
                        state_next    = vsh_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = vsh_pkg::ST_FILL;
                    end
                end
            end
            vsh_pkg::ST_FILL:
            begin
                fill_next  = fill_clamped;
                way_next   = '0;
                slot_raddr = {bucket_reg, {WB{1'b0}}};
                if (fill_clamped == '0)
                begin
                    // empty bucket: store in way 0 directly
                    fill_next  = '0;
                    slot_we    = 1'b1;
                    fill_we    = 1'b1;
                    fill_wdata = FB'(1);
                    res_next   = '{seen: 1'b0, full: 1'b0};
                    state_next = vsh_pkg::ST_FIN;
                end
                else
                begin
                    state_next = vsh_pkg::ST_CMP;
                end
            end
            vsh_pkg::ST_CMP:
            begin
                if (slot_match)
                begin
                    res_next   = '{seen: 1'b1, full: 1'b0};
                    state_next = vsh_pkg::ST_FIN;
                end
                else if (way_plus < fill_reg)
                begin
                    way_next = way_plus;
                end
                else if (fill_reg == FB'(vsh_pkg::BUCKET_WAYS))
                begin
                    res_next   = '{seen: 1'b0, full: 1'b1};
                    state_next = vsh_pkg::ST_FIN;
                end
                else
                begin
                    slot_we    = 1'b1;
                    fill_we    = 1'b1;
                    res_next   = '{seen: 1'b0, full: 1'b0};
                    state_next = vsh_pkg::ST_FIN;
                end
            end
            vsh_pkg::ST_FIN:
            begin
                if (load_ready)
                begin
                    clr_item_next = 1'b0;
                    state_next    = vsh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vsh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vsh_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        bucket_reg <= bucket_next;
        fill_reg   <= fill_next;
        way_reg    <= way_next;
        res_reg    <= res_next;
    end

    vsh_ram #(
        .WIDTH (FB),
        .DEPTH (vsh_pkg::NUM_BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    vsh_ram #(
        .WIDTH (vsh_pkg::SIG_W),
        .DEPTH (vsh_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (key_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    vsh_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_res     (res_reg),
        .load_ready   (load_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .already_seen (already_seen),
        .bucket_full  (bucket_full)
    );

endmodule

// ===== test/testbench.sv =====
// Testbench for visited_signature_hash_set: directed and random test-and-insert and clear
// transfers, with an internal hash-set predictor checking every result. Needs vsh_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

    import vsh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_PAD   = 16;
    localparam int MAX_GAP     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int HOT_COUNT   = 12;
    localparam int POOL_DEPTH  = 64;
    localparam int REPORT_MAX  = 10;

    class visited_set_scoreboard;
        logic [FILL_BITS-1:0] bucket_count [NUM_BUCKETS];
        sig_t                 stored_sig [SLOT_COUNT];
        result_t              verdict_q [$];
        int                   failures;

        function new();
            foreach (bucket_count[b])
                bucket_count[b] = '0;
            failures = 0;
        endfunction

        function void record_item(logic k, logic [PATH_W-1:0] p, logic [DEV_W-1:0] d,
                                  logic [TYPE_W-1:0] t);
            result_t verdict;
            sig_t    key;
            int      bucket;
            int      base;
            int      fill;
            verdict = '0;
            key = {p, d, t};
            if (k == KIND_CLEAR)
            begin
                foreach (bucket_count[b])
                    bucket_count[b] = '0;
            end
            else
            begin
                bucket = int'(p % 64'(NUM_BUCKETS));
                base   = bucket * BUCKET_WAYS;
                fill   = bucket_count[bucket];
                for (int w = 0; w < fill; w++)
                    if (stored_sig[base + w] == key)
                        verdict.seen = 1'b1;
                if (!verdict.seen)
                begin
                    if (fill >= BUCKET_WAYS)
                        verdict.full = 1'b1;
                    else
                    begin
                        stored_sig[base + fill] = key;
                        bucket_count[bucket] = FILL_BITS'(fill + 1);
                    end
                end
            end
            verdict_q.push_back(verdict);
        endfunction

        function void note_failure(string what, result_t want, logic seen, logic full);
            failures++;
            if (failures <= REPORT_MAX)
                $display("%0t: %0s: expected already_seen=%0b bucket_full=%0b, got %0b %0b",
                         $time, what, want.seen, want.full, seen, full);
        endfunction

        function void check_verdict(logic seen, logic full);
            result_t want;
            if (verdict_q.size() == 0)
                note_failure("result with nothing outstanding", '0, seen, full);
            else
            begin
                want = verdict_q.pop_front();
                if (seen !== want.seen)
                    note_failure("already_seen mismatch", want, seen, full);
                else if (full !== want.full)
                    note_failure("bucket_full mismatch", want, seen, full);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] path_id;
    logic [31:0] device_num;
    logic [7:0]  server_type;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        already_seen;
    logic        bucket_full;

    visited_set_scoreboard sb;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    holds_requested;
    int                    holds_started;
    int                    hold_left;
    int                    cycle_count;
    logic [BUCKET_BITS-1:0] hot_bucket [HOT_COUNT];
    sig_t                  sig_pool [$];

    visited_signature_hash_set dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .path_id      (path_id),
        .device_num   (device_num),
        .server_type  (server_type),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .already_seen (already_seen),
        .bucket_full  (bucket_full)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: check, then random stall or a long hold-off
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_verdict(already_seen, bucket_full);
        if (holds_started < holds_requested)
        begin
            holds_started = holds_started + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic offer_item(input logic k, input logic [63:0] p, input logic [31:0] d,
                              input logic [7:0] t);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        path_id     <= p;
        device_num  <= d;
        server_type <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.record_item(k, p, d, t);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic run_directed();
        offer_item(KIND_CLEAR, '1, '1, '1);
        offer_item(KIND_TEST, 64'h0, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h0, 32'h0, 8'h00);
        offer_item(KIND_TEST, '1, '1, '1);
        offer_item(KIND_TEST, '1, '1, '1);
        // fill bucket zero, then overflow it
        offer_item(KIND_TEST, 64'h1000, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h2000, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h3000, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h4000, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h2000, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h0, 32'h1, 8'h00);
        // near misses in the top bucket
        offer_item(KIND_TEST, '1, '1, 8'hFE);
        offer_item(KIND_TEST, '1, 32'hFFFF_FFFE, 8'hFF);
        offer_item(KIND_TEST, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1);
        offer_item(KIND_TEST, 64'hBFFF_FFFF_FFFF_FFFF, '1, '1);
        offer_item(KIND_CLEAR, '1, '1, '1);
        offer_item(KIND_TEST, 64'h0, 32'h0, 8'h00);
        offer_item(KIND_TEST, 64'h0, 32'h0, 8'h00);
    endtask

    task automatic offer_random(input int count);
        sig_t s;
        int   sel;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(199) == 0)
                offer_item(KIND_CLEAR, {$urandom, $urandom}, $urandom, 8'($urandom));
            else
            begin
                sel = $urandom_range(99);
                if (sel < 60 && sig_pool.size() > 0)
                begin
                    s = sig_pool[$urandom_range(sig_pool.size() - 1)];
                    if (sel >= 35)
                        case ($urandom_range(2))
                            0: s.path[$urandom_range(PATH_W - 1, BUCKET_BITS)] ^= 1'b1;
                            1: s.dev[$urandom_range(DEV_W - 1)] ^= 1'b1;
                            default: s.typ[$urandom_range(TYPE_W - 1)] ^= 1'b1;
                        endcase
                end
                else
                begin
                    s.path = {$urandom, $urandom};
                    s.dev  = $urandom;
                    s.typ  = 8'($urandom);
                    if (sel < 85)
                        s.path[BUCKET_BITS-1:0] = hot_bucket[$urandom_range(HOT_COUNT - 1)];
                end
                offer_item(KIND_TEST, s.path, s.dev, s.typ);
                sig_pool.push_back(s);
                if (sig_pool.size() > POOL_DEPTH)
                    void'(sig_pool.pop_front());
            end
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holds_requested = 0;
        holds_started   = 0;
        hold_left       = 0;
        foreach (hot_bucket[h])
            hot_bucket[h] = BUCKET_BITS'($urandom);
        hot_bucket[0] = '0;
        hot_bucket[1] = '1;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_TEST;
        path_id     <= '0;
        device_num  <= '0;
        server_type <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        offer_random(220);
        wait_drained();

        // long receiver hold-off while items keep coming
        holds_requested = holds_requested + 1;
        offer_random(40);
        wait_drained();

        send_idle_pct = 80;
        offer_random(250);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 80;
        offer_random(250);
        wait_drained();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        offer_random(250);
        wait_drained();

        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
